// ----- rtl/tssc_pkg.sv -----
package tssc_pkg;

    // Field widths
    localparam int TEMP_W  = 15;
    localparam int VALUE_W = 14;
    localparam int WHOLE_W = 10;
    localparam int W100_W  = 7;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 7;
    localparam int EN_W    = 5;
    localparam int POS_W   = 3;

    // Clamp and blanking limits
    localparam logic [VALUE_W-1:0] VALUE_MAX            = 14'd9999;
    localparam logic [VALUE_W-1:0] HUNDREDS_SHOWN_FROM  = 14'd1000;
    localparam logic [VALUE_W-1:0] TENS_SHOWN_FROM      = 14'd100;

    // Divide by ten: (x * 52429) >> 19 is exact for x below 43690
    localparam int RECIP10_W   = 16;
    localparam logic [RECIP10_W-1:0] RECIP10 = 16'd52429;
    localparam int RECIP10_SHIFT = 19;
    localparam int PROD_W        = RECIP10_SHIFT + VALUE_W;

    // Display positions
    localparam logic [POS_W-1:0] POS_HUNDREDS = 3'd0;
    localparam logic [POS_W-1:0] POS_TENS     = 3'd1;
    localparam logic [POS_W-1:0] POS_UNITS    = 3'd2;
    localparam logic [POS_W-1:0] POS_TENTHS   = 3'd3;
    localparam logic [POS_W-1:0] POS_SYMBOL   = 3'd4;

    localparam logic [SEG_W-1:0] SEG_SYMBOL_C = 7'h39;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic               blank;
    } t_task;

    function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP10);
        return prod[RECIP10_SHIFT +: VALUE_W];
    endfunction

    function automatic logic [DIGIT_W-1:0] rem10(input logic [VALUE_W-1:0] x,
                                                 input logic [VALUE_W-1:0] q);
        logic [VALUE_W-1:0] r;
        r = x - ((q << 3) + (q << 1));
        return r[DIGIT_W-1:0];
    endfunction

    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h6F;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/tssc_temp_if.sv -----
interface tssc_temp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [tssc_pkg::TEMP_W-1:0]      temperature_tenths;

    modport source (output valid, output temperature_tenths, input ready);
    modport sink   (input valid, input temperature_tenths, output ready);
endinterface

// ----- rtl/tssc_disp_if.sv -----
interface tssc_disp_if;
    logic                          valid;
    logic                          ready;
    logic [tssc_pkg::SEG_W-1:0]    segments;
    logic [tssc_pkg::EN_W-1:0]     digit_enable;
    logic                          decimal_point;
    logic [tssc_pkg::POS_W-1:0]    position;

    modport source (output valid, output segments, output digit_enable,
                    output decimal_point, output position, input ready);
    modport sink   (input valid, input segments, input digit_enable,
                    input decimal_point, input position, output ready);
endinterface

// ----- rtl/tssc_front.sv -----
module tssc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tssc_temp_if.sink       i_temp,
    input  logic            i_push_ready,
    output logic            o_push_valid,
    output tssc_pkg::t_task o_push_task
);

    logic [tssc_pkg::POS_W-1:0]   r_scan_pos;
    logic [tssc_pkg::POS_W-1:0]   n_scan_pos;
    logic [tssc_pkg::VALUE_W-1:0] value;
    logic                         accept;

    assign i_temp.ready = i_push_ready;
    assign accept       = i_temp.valid && i_push_ready;
    assign o_push_valid = i_temp.valid;

    // Clamp negative to zero and large values to the display limit
    always_comb begin
        if (i_temp.temperature_tenths[tssc_pkg::TEMP_W-1]) begin
            value = '0;
        end else if (i_temp.temperature_tenths[tssc_pkg::VALUE_W-1:0] > tssc_pkg::VALUE_MAX) begin
            value = tssc_pkg::VALUE_MAX;
        end else begin
            value = i_temp.temperature_tenths[tssc_pkg::VALUE_W-1:0];
        end
    end

    always_comb begin
        case (r_scan_pos)
            tssc_pkg::POS_HUNDREDS: n_scan_pos = tssc_pkg::POS_TENS;
            tssc_pkg::POS_TENS:     n_scan_pos = tssc_pkg::POS_UNITS;
            tssc_pkg::POS_UNITS:    n_scan_pos = tssc_pkg::POS_TENTHS;
            tssc_pkg::POS_TENTHS:   n_scan_pos = tssc_pkg::POS_SYMBOL;
            default:                n_scan_pos = tssc_pkg::POS_HUNDREDS;
        endcase
    end

    // Tag the word with its position and decide leading-zero blanking here
    always_comb begin
        o_push_task.value = value;
        o_push_task.pos   = (r_scan_pos > tssc_pkg::POS_SYMBOL) ? tssc_pkg::POS_HUNDREDS
                                                                 : r_scan_pos;
        o_push_task.blank =
            ((o_push_task.pos == tssc_pkg::POS_HUNDREDS) && (value < tssc_pkg::HUNDREDS_SHOWN_FROM)) ||
            ((o_push_task.pos == tssc_pkg::POS_TENS) && (value < tssc_pkg::TENS_SHOWN_FROM));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= tssc_pkg::POS_HUNDREDS;
        end else if (accept) begin
            r_scan_pos <= n_scan_pos;
        end
    end

endmodule

// ----- rtl/tssc_queue.sv -----
module tssc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  tssc_pkg::t_task i_push_task,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output tssc_pkg::t_task o_pop_task,
    input  logic            i_pop_ready
);

    tssc_pkg::t_task             r_mem [tssc_pkg::QUEUE_DEPTH];
    logic [tssc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [tssc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [tssc_pkg::QCNT_W-1:0] r_count;
    logic                        push;
    logic                        pop;

    assign o_push_ready = (r_count != tssc_pkg::QCNT_W'(tssc_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_task   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [tssc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tssc_pkg::QPTR_W-1:0] p);
        if (p == tssc_pkg::QPTR_W'(tssc_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/tssc_back.sv -----
module tssc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    input  tssc_pkg::t_task i_pop_task,
    output logic            o_pop_ready,
    tssc_disp_if.source     o_disp
);

    // Stage 1: clamped value
    logic                         r_s1_valid;
    tssc_pkg::t_task              r_s1_task;
    logic [tssc_pkg::VALUE_W-1:0] s1_q;
    logic [tssc_pkg::DIGIT_W-1:0] s1_tenths;

    // Stage 2: whole degrees
    logic                         r_s2_valid;
    logic [tssc_pkg::WHOLE_W-1:0] r_s2_whole;
    logic [tssc_pkg::DIGIT_W-1:0] r_s2_tenths;
    logic [tssc_pkg::POS_W-1:0]   r_s2_pos;
    logic                         r_s2_blank;
    logic [tssc_pkg::VALUE_W-1:0] s2_q;
    logic [tssc_pkg::DIGIT_W-1:0] s2_units;

    // Stage 3: whole / 10
    logic                         r_s3_valid;
    logic [tssc_pkg::W100_W-1:0]  r_s3_w100;
    logic [tssc_pkg::DIGIT_W-1:0] r_s3_units;
    logic [tssc_pkg::DIGIT_W-1:0] r_s3_tenths;
    logic [tssc_pkg::POS_W-1:0]   r_s3_pos;
    logic                         r_s3_blank;
    logic [tssc_pkg::VALUE_W-1:0] s3_q;
    logic [tssc_pkg::DIGIT_W-1:0] s3_tens;
    logic [tssc_pkg::DIGIT_W-1:0] s3_digit;
    logic [tssc_pkg::SEG_W-1:0]   s3_seg;

    // Output register
    logic                         r_out_valid;
    logic [tssc_pkg::SEG_W-1:0]   r_seg;
    logic [tssc_pkg::EN_W-1:0]    r_en;
    logic                         r_dp;
    logic [tssc_pkg::POS_W-1:0]   r_pos;

    logic free_out;
    logic free3;
    logic free2;
    logic free1;

    // A stage takes new data when it is empty or its contents move on
    assign free_out    = !r_out_valid || o_disp.ready;
    assign free3       = !r_s3_valid || free_out;
    assign free2       = !r_s2_valid || free3;
    assign free1       = !r_s1_valid || free2;
    assign o_pop_ready = free1;

    assign s1_q      = tssc_pkg::div10(r_s1_task.value);
    assign s1_tenths = tssc_pkg::rem10(r_s1_task.value, s1_q);

    assign s2_q     = tssc_pkg::div10(tssc_pkg::VALUE_W'(r_s2_whole));
    assign s2_units = tssc_pkg::rem10(tssc_pkg::VALUE_W'(r_s2_whole), s2_q);

    assign s3_q    = tssc_pkg::div10(tssc_pkg::VALUE_W'(r_s3_w100));
    assign s3_tens = tssc_pkg::rem10(tssc_pkg::VALUE_W'(r_s3_w100), s3_q);

    always_comb begin
        case (r_s3_pos)
            tssc_pkg::POS_HUNDREDS: s3_digit = s3_q[tssc_pkg::DIGIT_W-1:0];
            tssc_pkg::POS_TENS:     s3_digit = s3_tens;
            tssc_pkg::POS_UNITS:    s3_digit = r_s3_units;
            tssc_pkg::POS_TENTHS:   s3_digit = r_s3_tenths;
            default:                s3_digit = '0;
        endcase
        s3_seg = (r_s3_pos == tssc_pkg::POS_SYMBOL) ? tssc_pkg::SEG_SYMBOL_C
                                                     : tssc_pkg::seg_decode(s3_digit);
    end

    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_task <= i_pop_task;
        end
        if (free2) begin
            r_s2_whole  <= s1_q[tssc_pkg::WHOLE_W-1:0];
            r_s2_tenths <= s1_tenths;
            r_s2_pos    <= r_s1_task.pos;
            r_s2_blank  <= r_s1_task.blank;
        end
        if (free3) begin
            r_s3_w100   <= s2_q[tssc_pkg::W100_W-1:0];
            r_s3_units  <= s2_units;
            r_s3_tenths <= r_s2_tenths;
            r_s3_pos    <= r_s2_pos;
            r_s3_blank  <= r_s2_blank;
        end
        if (free_out) begin
            r_seg <= s3_seg;
            r_en  <= r_s3_blank ? '0 : (tssc_pkg::EN_W'(1) << r_s3_pos);
            r_dp  <= (r_s3_pos == tssc_pkg::POS_UNITS);
            r_pos <= r_s3_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (free1) begin
                r_s1_valid <= i_pop_valid;
            end
            if (free2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (free3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (free_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    assign o_disp.valid         = r_out_valid;
    assign o_disp.segments      = r_seg;
    assign o_disp.digit_enable  = r_en;
    assign o_disp.decimal_point = r_dp;
    assign o_disp.position      = r_pos;

endmodule

// ----- rtl/temperature_seven_segment_scanner.sv -----
// A word accepted from i_temp passes through the queue, three divide-by-ten stages and
// the output register; throughput is one word per cycle while the display accepts words.
// The rate is set by the chain of pipeline registers, each stalling only on its successor.
// Reset (i_rst_n low at a rising edge) empties the queue and pipeline and sets the
// scan position back to the hundreds digit.
module temperature_seven_segment_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tssc_temp_if.sink   i_temp,
    tssc_disp_if.source o_disp
);

    // Front to queue
    logic            push_valid;
    logic            push_ready;
    tssc_pkg::t_task push_task;

    // Queue to back
    logic            pop_valid;
    logic            pop_ready;
    tssc_pkg::t_task pop_task;

    // Front: clamp the reading, tag it with the scan position, and decide
    // whether a leading zero is blanked. The scan counter advances per word.
    tssc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_temp       (i_temp),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_task  (push_task)
    );

    // Two-entry queue: lets the front keep taking words while the display side
    // stalls, until the queue fills.
    tssc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_task  (push_task),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_task   (pop_task),
        .i_pop_ready  (pop_ready)
    );

    // Back: split the value into digits with one reciprocal multiply per
    // stage, pick the digit for the position, decode it and register the result.
    tssc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_task  (pop_task),
        .o_pop_ready (pop_ready),
        .o_disp      (o_disp)
    );

endmodule

// ----- rtl/tssc_checker.sv -----
module tssc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_disp_valid,
    input logic                         i_disp_ready,
    input logic [tssc_pkg::SEG_W-1:0]   i_segments,
    input logic [tssc_pkg::EN_W-1:0]    i_digit_enable,
    input logic                         i_decimal_point,
    input logic [tssc_pkg::POS_W-1:0]   i_position
);

    logic [tssc_pkg::POS_W-1:0] r_last_pos;
    logic [tssc_pkg::POS_W-1:0] expect_pos;
    logic                       out_word;

    assign out_word   = i_disp_valid && i_disp_ready;
    assign expect_pos = (r_last_pos == tssc_pkg::POS_SYMBOL) ? tssc_pkg::POS_HUNDREDS
                                                              : r_last_pos + 1'b1;

    // Track the position of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= tssc_pkg::POS_SYMBOL;
        end else if (out_word) begin
            r_last_pos <= i_position;
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_disp_valid && !i_disp_ready |=> i_disp_valid && $stable(i_segments) &&
        $stable(i_digit_enable) && $stable(i_position))
        else $error("display word changed while stalled");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_word |-> i_position == expect_pos)
        else $error("display position out of scan order");

    a_enable_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_disp_valid |-> (i_digit_enable == '0 ||
                          i_digit_enable == (tssc_pkg::EN_W'(1) << i_position)))
        else $error("digit enable does not match position");

    a_point_and_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_disp_valid |-> (i_decimal_point == (i_position == tssc_pkg::POS_UNITS)) &&
        ((i_position != tssc_pkg::POS_SYMBOL) || (i_segments == tssc_pkg::SEG_SYMBOL_C)))
        else $error("decimal point or symbol pattern wrong");

endmodule

bind temperature_seven_segment_scanner tssc_checker u_tssc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_disp_valid    (o_disp.valid),
    .i_disp_ready    (o_disp.ready),
    .i_segments      (o_disp.segments),
    .i_digit_enable  (o_disp.digit_enable),
    .i_decimal_point (o_disp.decimal_point),
    .i_position      (o_disp.position)
);

// ----- tb/temperature_seven_segment_scanner_tb.sv -----
`timescale 1ns / 100ps

module temperature_seven_segment_scanner_tb;

    // Random part length, idle limit and tail wait after the last result
    localparam int RANDOM_WORDS = 1680;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int REPORT_MAX   = 10;

    // One display word, laid out field by field as the result channel carries it
    typedef struct packed {
        logic [tssc_pkg::SEG_W-1:0] segments;
        logic [tssc_pkg::EN_W-1:0]  digit_enable;
        logic                       decimal_point;
        logic [tssc_pkg::POS_W-1:0] position;
    } t_disp_word;

    // One directed row: the temperature word, and a typed-in display word where
    // the answer is obvious; other rows fall back on the predictor
    typedef struct packed {
        logic [tssc_pkg::TEMP_W-1:0] temp;
        logic                        typed;
        t_disp_word                  want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;

    // Rows start right after reset, so row n drives position n mod 5.
    // 15'h4000 is the most negative reading, 15'h7FFF is -1, 15'h3FFF the largest.
    t_stim_row directed_table [DIRECTED_ROWS] = '{
        // negative readings clamp to 0: both leading digits blank
        '{15'h4000, 1'b1, '{7'h3F, 5'b00000, 1'b0, tssc_pkg::POS_HUNDREDS}},
        '{15'h7FFF, 1'b1, '{7'h3F, 5'b00000, 1'b0, tssc_pkg::POS_TENS}},
        '{15'd0,    1'b1, '{7'h3F, 5'b00100, 1'b1, tssc_pkg::POS_UNITS}},
        // top of the range clamps to 999.9, with a negative reading at the tenths position
        '{15'h3FFF, 1'b1, '{7'h6F, 5'b01000, 1'b0, tssc_pkg::POS_TENTHS}},
        '{15'd9999, 1'b1, '{tssc_pkg::SEG_SYMBOL_C, 5'b10000, 1'b0, tssc_pkg::POS_SYMBOL}},
        '{15'd9999, 1'b1, '{7'h6F, 5'b00001, 1'b0, tssc_pkg::POS_HUNDREDS}},
        '{15'd10000, 1'b1, '{7'h6F, 5'b00010, 1'b0, tssc_pkg::POS_TENS}},
        '{15'h3FFF, 1'b1, '{7'h6F, 5'b00100, 1'b1, tssc_pkg::POS_UNITS}},
        '{15'h4000, 1'b1, '{7'h3F, 5'b01000, 1'b0, tssc_pkg::POS_TENTHS}},
        '{15'd12345, 1'b1, '{tssc_pkg::SEG_SYMBOL_C, 5'b10000, 1'b0, tssc_pkg::POS_SYMBOL}},
        // leading-zero blanking and every digit on its own position
        '{15'd999,  1'b0, '0},
        '{15'd1000, 1'b0, '0},
        '{15'd5678, 1'b0, '0},
        '{15'd1234, 1'b0, '0},
        '{15'h7FF6, 1'b0, '0},
        '{15'd1000, 1'b0, '0},
        '{15'd99,   1'b0, '0},
        '{15'd100,  1'b0, '0},
        '{15'd3456, 1'b0, '0},
        '{15'd8,    1'b0, '0},
        '{15'd4321, 1'b0, '0},
        '{15'd100,  1'b0, '0},
        '{15'd2468, 1'b0, '0},
        '{15'd8008, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    tssc_temp_if temp_bus ();
    tssc_disp_if disp_bus ();

    temperature_seven_segment_scanner i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_temp  (temp_bus),
        .o_disp  (disp_bus)
    );

    // Predictor state and the store of display words still owed by the block
    logic [tssc_pkg::POS_W-1:0] scan_slot;
    t_disp_word                 owed_display [$];
    t_stim_row                  row_notes [$];

    int mismatches;
    int unexpected_words;
    int words_sent;
    int words_checked;
    int blanked_seen;
    int clamped_low;
    int clamped_high;
    int idle_cycles;
    int gap_mode;
    int stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Segment pattern of one decimal digit, bit0 = a through bit6 = g
    function automatic logic [tssc_pkg::SEG_W-1:0] glyph_of(input int digit);
        case (digit)
            0: return 7'h3F;
            1: return 7'h06;
            2: return 7'h5B;
            3: return 7'h4F;
            4: return 7'h66;
            5: return 7'h6D;
            6: return 7'h7D;
            7: return 7'h07;
            8: return 7'h7F;
            default: return 7'h6F;
        endcase
    endfunction

    // Display word for one scan tick: clamp, split into digits, pick the slot
    function automatic t_disp_word predict_display(input logic [tssc_pkg::TEMP_W-1:0] raw,
                                                   input logic [tssc_pkg::POS_W-1:0] slot);
        int value;
        int whole;
        int hundreds;
        int tens;
        t_disp_word w;
        if (raw[tssc_pkg::TEMP_W-1])
            value = 0;
        else if (raw > tssc_pkg::TEMP_W'(tssc_pkg::VALUE_MAX))
            value = int'(tssc_pkg::VALUE_MAX);
        else
            value = int'(raw);
        whole    = value / 10;
        hundreds = whole / 100;
        tens     = (whole % 100) / 10;
        w.position      = slot;
        w.decimal_point = 1'b0;
        case (slot)
            tssc_pkg::POS_HUNDREDS: begin
                w.segments     = glyph_of(hundreds);
                w.digit_enable = (hundreds != 0) ? 5'b00001 : 5'b00000;
            end
            tssc_pkg::POS_TENS: begin
                // tens stays lit whenever anything above it is lit
                w.segments     = glyph_of(tens);
                w.digit_enable = (hundreds != 0 || tens != 0) ? 5'b00010 : 5'b00000;
            end
            tssc_pkg::POS_UNITS: begin
                w.segments      = glyph_of(whole % 10);
                w.digit_enable  = 5'b00100;
                w.decimal_point = 1'b1;
            end
            tssc_pkg::POS_TENTHS: begin
                w.segments     = glyph_of(value % 10);
                w.digit_enable = 5'b01000;
            end
            default: begin
                w.segments     = tssc_pkg::SEG_SYMBOL_C;
                w.digit_enable = 5'b10000;
            end
        endcase
        return w;
    endfunction

    // Both channels are sampled here, on the edge, before any drive settles.
    // Predict on an accepted temperature word first, then check a display word.
    always @(posedge i_clk) begin
        t_disp_word got;
        t_disp_word want;
        t_stim_row  note;
        if (!i_rst_n) begin
            scan_slot <= tssc_pkg::POS_HUNDREDS;
        end else begin
            if (temp_bus.valid && temp_bus.ready) begin
                note = row_notes.pop_front();
                want = predict_display(temp_bus.temperature_tenths, scan_slot);
                owed_display.push_back(note.typed ? note.want : want);
                if (temp_bus.temperature_tenths[tssc_pkg::TEMP_W-1])
                    clamped_low++;
                else if (temp_bus.temperature_tenths >
                         tssc_pkg::TEMP_W'(tssc_pkg::VALUE_MAX))
                    clamped_high++;
                // wrap after the symbol position
                scan_slot <= (scan_slot == tssc_pkg::POS_SYMBOL) ? tssc_pkg::POS_HUNDREDS
                                                                  : scan_slot + 1'b1;
            end
            if (disp_bus.valid && disp_bus.ready) begin
                got = '{disp_bus.segments, disp_bus.digit_enable,
                        disp_bus.decimal_point, disp_bus.position};
                if (owed_display.size() == 0) begin
                    unexpected_words++;
                    if (mismatches + unexpected_words <= REPORT_MAX)
                        $display("%0t: display word with none owed: seg=%h en=%b dp=%b pos=%0d",
                                 $realtime, got.segments, got.digit_enable,
                                 got.decimal_point, got.position);
                end else begin
                    want = owed_display.pop_front();
                    words_checked++;
                    if (got.digit_enable == '0)
                        blanked_seen++;
                    if (got.segments !== want.segments
                        || got.digit_enable !== want.digit_enable
                        || got.decimal_point !== want.decimal_point
                        || got.position !== want.position) begin
                        mismatches++;
                        if (mismatches + unexpected_words <= REPORT_MAX)
                            $display({"%0t: display mismatch: seg exp=%h got=%h, en exp=%b got=%b,",
                                      " dp exp=%b got=%b, pos exp=%0d got=%0d"},
                                     $realtime, want.segments, got.segments,
                                     want.digit_enable, got.digit_enable,
                                     want.decimal_point, got.decimal_point,
                                     want.position, got.position);
                    end
                end
            end
        end
    end

    // Drop the run when neither side moves a word for too long
    always @(posedge i_clk) begin
        if ((temp_bus.valid && temp_bus.ready) || (disp_bus.valid && disp_bus.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d display words still owed",
                     $realtime, IDLE_LIMIT, owed_display.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one temperature word after a random gap; return on the edge that takes it.
    // Called on an edge; valid is lowered only when a gap is drawn, so it never
    // gets two updates in one step.
    task automatic send_temperature(input t_stim_row row);
        int gap;
        gap = (gap_mode == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            temp_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        temp_bus.valid              <= 1'b1;
        temp_bus.temperature_tenths <= row.temp;
        row_notes.push_back(row);
        words_sent++;
        do @(posedge i_clk); while (!temp_bus.ready);
    endtask

    // Hold the sender until every owed display word has come back
    task automatic wait_for_display_drain();
        temp_bus.valid <= 1'b0;
        do @(posedge i_clk); while (owed_display.size() != 0);
    endtask

    // Pick a random temperature, weighted toward blanking and clamp edges
    function automatic logic [tssc_pkg::TEMP_W-1:0] pick_temperature();
        case ($urandom_range(0, 9))
            0, 1, 2: return tssc_pkg::TEMP_W'($urandom_range(0, 9999));
            3:       return tssc_pkg::TEMP_W'($urandom_range(0, 99));
            4:       return tssc_pkg::TEMP_W'($urandom_range(100, 999));
            5, 6:    return tssc_pkg::TEMP_W'($urandom);
            7:       return tssc_pkg::TEMP_W'($urandom_range(9990, 10010));
            8:       return tssc_pkg::TEMP_W'($urandom_range(0, 10)) - tssc_pkg::TEMP_W'(5);
            default: return tssc_pkg::TEMP_W'($urandom_range(990, 1010));
        endcase
    endfunction

    // Sink side: stall a random number of cycles before each display word
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (taken % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            stall = (stall_mode == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                disp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            disp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!disp_bus.valid);
            taken++;
        end
    end

    initial begin
        t_stim_row row;
        mismatches       = 0;
        unexpected_words = 0;
        words_sent       = 0;
        words_checked    = 0;
        blanked_seen     = 0;
        clamped_low      = 0;
        clamped_high     = 0;
        gap_mode         = 1;
        i_rst_n                     <= 1'b0;
        temp_bus.valid              <= 1'b0;
        temp_bus.temperature_tenths <= '0;
        disp_bus.ready              <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, with gaps, from the known post-reset position
        for (int n = 0; n < DIRECTED_ROWS; n++)
            send_temperature(directed_table[n]);
        wait_for_display_drain();

        // Random words in blocks of 100, each block back-to-back or gapped at random
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0)
                gap_mode = $urandom_range(0, 2);
            if (n == RANDOM_WORDS / 2)
                wait_for_display_drain();
            row.temp  = pick_temperature();
            row.typed = 1'b0;
            row.want  = '0;
            send_temperature(row);
        end
        wait_for_display_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d temperature words and checked %0d display words.",
                 words_sent, words_checked);
        $display("Saw %0d blanked digits, %0d readings clamped low and %0d clamped high.",
                 blanked_seen, clamped_low, clamped_high);
        if (mismatches == 0 && unexpected_words == 0 && owed_display.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d unexpected words, %0d words never came",
                     mismatches, unexpected_words, owed_display.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
